@@ rtl/skrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skrt_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int AVG_W  = 14;
  localparam int STAT_W = 3;
  localparam int CMD_W  = 2;

  localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(10000);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [AVG_W-1:0]        avg;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // one write and one read port into the record memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/skrt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skrt_ram #(
  parameter int DEPTH = 64,
  parameter int DATA_W = 46,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/skrt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skrt_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [skrt_pkg::CMD_W-1:0]        cmd,
  input  wire logic signed [skrt_pkg::KEY_W-1:0] key_in,
  input  wire logic [skrt_pkg::AVG_W-1:0]        average_in,
  output logic                                   busy,
  output logic                                   strobe,
  output logic [skrt_pkg::STAT_W-1:0]            status,
  output logic signed [skrt_pkg::KEY_W-1:0]      key_out,
  output logic [skrt_pkg::AVG_W-1:0]             average_out,
  output logic [skrt_pkg::CNT_W-1:0]             entry_count,
  output logic                                   last_result,
  output skrt_pkg::mem_req_t                     mem_req,
  input  wire skrt_pkg::rec_t                    rd_rec
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;
  localparam logic [2:0] S_LIST = 3'd5;

  localparam logic [skrt_pkg::CNT_W-1:0] FULL_CNT = skrt_pkg::CNT_W'(skrt_pkg::DEPTH);

  logic [2:0]                          state;
  logic [skrt_pkg::CMD_W-1:0]          cmd_r;
  logic signed [skrt_pkg::KEY_W-1:0]   key_r;
  logic [skrt_pkg::AVG_W-1:0]          avg_r;
  logic [skrt_pkg::AVG_W-1:0]          found_avg;
  logic [skrt_pkg::CNT_W-1:0]          count;
  logic [skrt_pkg::CNT_W-1:0]          ptr;
  logic [skrt_pkg::CNT_W-1:0]          left;
  logic [skrt_pkg::CNT_W-1:0]          pos;
  logic [skrt_pkg::CNT_W-1:0]          rd_idx;
  logic                                rd_vld;

  logic                                walking;
  logic                                hit;
  logic                                scan_end;
  logic                                issue;
  logic                                eq;
  logic [skrt_pkg::CNT_W-1:0]          p;

  // first stored key not below the search key ends the scan
  assign walking  = (state == S_SCAN) || (state == S_UP) || (state == S_DOWN) ||
                    (state == S_LIST);
  assign hit      = (state == S_SCAN) && rd_vld && !(rd_rec.key < key_r);
  assign scan_end = (state == S_SCAN) && rd_vld && (left == '0) && !hit;
  assign issue    = walking && (left != '0) && !hit;
  assign eq       = hit && (rd_rec.key == key_r);
  assign p        = hit ? rd_idx : count;
  assign busy     = (state != S_IDLE);

  always_comb begin
    mem_req       = '0;
    mem_req.re    = issue;
    mem_req.raddr = ptr[skrt_pkg::IDX_W-1:0];
    case (state)
      S_UP: begin
        mem_req.we    = rd_vld;
        mem_req.waddr = skrt_pkg::IDX_W'(rd_idx + 1'b1);
        mem_req.wdata = rd_rec;
      end
      S_DOWN: begin
        mem_req.we    = rd_vld;
        mem_req.waddr = skrt_pkg::IDX_W'(rd_idx - 1'b1);
        mem_req.wdata = rd_rec;
      end
      S_INS: begin
        mem_req.we        = 1'b1;
        mem_req.waddr     = pos[skrt_pkg::IDX_W-1:0];
        mem_req.wdata.key = key_r;
        mem_req.wdata.avg = avg_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      rd_vld <= issue;
      rd_idx <= ptr;
      if (issue) begin
        ptr  <= (state == S_UP) ? ptr - 1'b1 : ptr + 1'b1;
        left <= left - 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            key_r <= key_in;
            avg_r <= (average_in > skrt_pkg::AVG_MAX) ? skrt_pkg::AVG_MAX : average_in;
            if (count == '0) begin
              if (cmd == skrt_pkg::CMD_INSERT) begin
                pos   <= '0;
                state <= S_INS;
              end else begin
                strobe      <= 1'b1;
                status      <= skrt_pkg::ST_EMPTY;
                key_out     <= (cmd == skrt_pkg::CMD_LIST) ? '0 : key_in;
                average_out <= '0;
                entry_count <= count;
                last_result <= 1'b1;
              end
            end else begin
              ptr   <= '0;
              left  <= count;
              state <= (cmd == skrt_pkg::CMD_LIST) ? S_LIST : S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit || scan_end) begin
            if (cmd_r == skrt_pkg::CMD_INSERT) begin
              if (eq || (count == FULL_CNT)) begin
                strobe      <= 1'b1;
                status      <= eq ? skrt_pkg::ST_DUP : skrt_pkg::ST_FULL;
                key_out     <= key_r;
                average_out <= '0;
                entry_count <= count;
                last_result <= 1'b1;
                state       <= S_IDLE;
              end else if (p == count) begin
                pos   <= p;
                state <= S_INS;
              end else begin
                pos   <= p;
                ptr   <= count - 1'b1;
                left  <= count - p;
                state <= S_UP;
              end
            end else if (!eq) begin
              strobe      <= 1'b1;
              status      <= skrt_pkg::ST_NOTFOUND;
              key_out     <= key_r;
              average_out <= '0;
              entry_count <= count;
              last_result <= 1'b1;
              state       <= S_IDLE;
            end else if ((cmd_r == skrt_pkg::CMD_SEARCH) || (p + 1'b1 == count)) begin
              // search, or removal of the top record: nothing to move
              strobe      <= 1'b1;
              status      <= skrt_pkg::ST_OK;
              key_out     <= key_r;
              average_out <= rd_rec.avg;
              last_result <= 1'b1;
              state       <= S_IDLE;
              if (cmd_r == skrt_pkg::CMD_SEARCH) begin
                entry_count <= count;
              end else begin
                count       <= count - 1'b1;
                entry_count <= count - 1'b1;
              end
            end else begin
              found_avg <= rd_rec.avg;
              ptr       <= p + 1'b1;
              left      <= count - p - 1'b1;
              state     <= S_DOWN;
            end
          end
        end

        S_UP: begin
          if (rd_vld && (left == '0)) begin
            state <= S_INS;
          end
        end

        S_INS: begin
          count       <= count + 1'b1;
          strobe      <= 1'b1;
          status      <= skrt_pkg::ST_OK;
          key_out     <= key_r;
          average_out <= avg_r;
          entry_count <= count + 1'b1;
          last_result <= 1'b1;
          state       <= S_IDLE;
        end

        S_DOWN: begin
          if (rd_vld && (left == '0)) begin
            count       <= count - 1'b1;
            strobe      <= 1'b1;
            status      <= skrt_pkg::ST_OK;
            key_out     <= key_r;
            average_out <= found_avg;
            entry_count <= count - 1'b1;
            last_result <= 1'b1;
            state       <= S_IDLE;
          end
        end

        S_LIST: begin
          if (rd_vld) begin
            strobe      <= 1'b1;
            status      <= skrt_pkg::ST_OK;
            key_out     <= rd_rec.key;
            average_out <= rd_rec.avg;
            entry_count <= count;
            last_result <= (left == '0);
            if (left == '0) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_key_record_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/record table: up to DEPTH records (signed 32-bit key plus an
// average in hundredths), held in ascending key order in one memory.
// Request channel: start with cmd/key_in/average_in; a request is taken on
// a rising edge with start high and busy low. Commands: insert, remove,
// search and list all.
// Result channel: strobe marks each result for exactly one cycle; the
// receiver must take it then, it cannot stall the block. Each request gives
// one result, bar list, which streams one result per record on consecutive
// cycles; last_result flags the final one.
// An empty table answers search, remove and list straight from idle and
// writes an insert without a scan. Otherwise the single memory read port
// walks the entries one per cycle (scan up to the slot, then shift only the
// records above it); list reads every record in key order.
// Requests are taken one at a time; busy stays high until the final result
// and the next request may be taken in the cycle that carries it.
// Reset empties the table (count to zero); memory contents are not cleared.

module sorted_key_record_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [skrt_pkg::CMD_W-1:0]        cmd,
  input  wire logic signed [skrt_pkg::KEY_W-1:0] key_in,
  input  wire logic [skrt_pkg::AVG_W-1:0]        average_in,
  output logic                                   busy,
  output logic                                   strobe,
  output logic [skrt_pkg::STAT_W-1:0]            status,
  output logic signed [skrt_pkg::KEY_W-1:0]      key_out,
  output logic [skrt_pkg::AVG_W-1:0]             average_out,
  output logic [skrt_pkg::CNT_W-1:0]             entry_count,
  output logic                                   last_result
);

  skrt_pkg::mem_req_t            mem_req;
  logic [skrt_pkg::REC_W-1:0]    rdata;
  skrt_pkg::rec_t                rd_rec;

  assign rd_rec = skrt_pkg::rec_t'(rdata);

  // sequencer: scan, shift and list walks
  skrt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .key_in      (key_in),
    .average_in  (average_in),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .key_out     (key_out),
    .average_out (average_out),
    .entry_count (entry_count),
    .last_result (last_result),
    .mem_req     (mem_req),
    .rd_rec      (rd_rec)
  );

  // record store, one write and one registered read per cycle
  skrt_ram #(
    .DEPTH  (skrt_pkg::DEPTH),
    .DATA_W (skrt_pkg::REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

@@ rtl/skrt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skrt_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         busy,
  input wire logic                         strobe,
  input wire logic [skrt_pkg::STAT_W-1:0]  status,
  input wire logic [skrt_pkg::CNT_W-1:0]   entry_count,
  input wire logic                         last_result
);

  // any error closes the request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != skrt_pkg::ST_OK) |-> last_result)
    else $error("error result without last flag");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == skrt_pkg::ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with records held");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == skrt_pkg::ST_FULL) |->
      (entry_count == skrt_pkg::CNT_W'(skrt_pkg::DEPTH)))
    else $error("full status below capacity");

  // list stream has no gaps
  a_list_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |=> strobe && (status == skrt_pkg::ST_OK))
    else $error("gap in list stream");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_result |-> busy)
    else $error("idle during list stream");

endmodule

bind sorted_key_record_table skrt_checker u_skrt_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .strobe      (strobe),
  .status      (status),
  .entry_count (entry_count),
  .last_result (last_result)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Checks the sorted key/record table against a behavioural copy of the table
// kept here. Requests are queued up front, then driven one at a time with
// random gaps. Every strobed result is compared with the oldest expected one.
module tb;
  import skrt_pkg::*;

  localparam int HALF_PERIOD = 6;
  // Slowest request: an insert at the bottom of a near-full table, shifting every
  // record, plus the sender's gap; a list keeps strobing, so this is ample.
  localparam int IDLE_LIMIT  = 1000;
  // Quiet spell at the end, long enough to catch a stray trailing result.
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int POOL_SIZE   = 72;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic [AVG_W-1:0]        avg;
    logic [2:0]              gap;  // idle cycles after this request is taken
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] key;
    logic [AVG_W-1:0]        avg;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } table_result_t;

  // Block inputs: known values from time zero.
  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    start      = 1'b0;
  logic [CMD_W-1:0]        cmd        = CMD_INSERT;
  logic signed [KEY_W-1:0] key_in     = '0;
  logic [AVG_W-1:0]        average_in = '0;

  logic                    busy;
  logic                    strobe;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] key_out;
  logic [AVG_W-1:0]        average_out;
  logic [CNT_W-1:0]        entry_count;
  logic                    last_result;

  request_t      pending_requests [$];
  table_result_t expected_results [$];

  // Shadow of the table contents, ascending signed key order.
  logic signed [KEY_W-1:0] table_keys [DEPTH];
  logic [AVG_W-1:0]        table_avgs [DEPTH];
  int                      table_count = 0;
  int                      peak_count  = 0;

  int   mismatches      = 0;
  int   results_checked = 0;
  int   cmd_seen [4]    = '{default: 0};
  logic req_taken       = 1'b0;
  logic [2:0] gap_left  = '0;
  int   idle_cycles     = 0;
  bit   no_idle         = 1'b0;

  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  sorted_key_record_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .key_in      (key_in),
    .average_in  (average_in),
    .busy        (busy),
    .strobe      (strobe),
    .status      (status),
    .key_out     (key_out),
    .average_out (average_out),
    .entry_count (entry_count),
    .last_result (last_result)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap before the next request; forced to zero during back-to-back stretches.
  function automatic logic [2:0] draw_gap();
    return no_idle ? 3'd0 : 3'($urandom_range(0, 4));
  endfunction

  // Mostly in range, a fair share above 10000 to exercise saturation.
  function automatic logic [AVG_W-1:0] draw_avg();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return AVG_W'($urandom_range(0, 10000));
    if (r < 8) return AVG_W'($urandom_range(10001, 16383));
    if (r == 8) return '0;
    return AVG_MAX;
  endfunction

  // Pool keys give hits and duplicates; fresh keys give misses.
  function automatic logic signed [KEY_W-1:0] draw_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic void shuffle_pool();
    int j;
    logic signed [KEY_W-1:0] t;
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = key_pool[i];
      key_pool[i] = key_pool[j];
      key_pool[j] = t;
    end
  endfunction

  function automatic void push_request(logic [CMD_W-1:0] c, logic signed [KEY_W-1:0] k,
                                       logic [AVG_W-1:0] a);
    request_t r;
    r.cmd = c;
    r.key = k;
    r.avg = a;
    r.gap = draw_gap();
    pending_requests.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Table prediction
  // ---------------------------------------------------------------------------

  function automatic int find_slot(logic signed [KEY_W-1:0] k);
    for (int i = 0; i < table_count; i++)
      if (table_keys[i] == k) return i;
    return -1;
  endfunction

  // Entry count reflects the table after the command has taken effect.
  function automatic void queue_result(logic [STAT_W-1:0] st, logic signed [KEY_W-1:0] k,
                                       logic [AVG_W-1:0] a, logic lst);
    table_result_t r;
    r.status = st;
    r.key    = k;
    r.avg    = a;
    r.count  = CNT_W'(table_count);
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_table_command(logic [CMD_W-1:0] op,
                                              logic signed [KEY_W-1:0] k,
                                              logic [AVG_W-1:0] a_in);
    logic [AVG_W-1:0] a;
    int slot;
    cmd_seen[op]++;
    a = (a_in > AVG_MAX) ? AVG_MAX : a_in;
    slot = find_slot(k);
    case (op)
      CMD_INSERT: begin
        // duplicate takes priority over full
        if (slot >= 0) begin
          queue_result(ST_DUP, k, '0, 1'b1);
        end else if (table_count >= DEPTH) begin
          queue_result(ST_FULL, k, '0, 1'b1);
        end else begin
          slot = 0;
          while (slot < table_count && table_keys[slot] < k) slot++;
          for (int i = table_count; i > slot; i--) begin
            table_keys[i] = table_keys[i-1];
            table_avgs[i] = table_avgs[i-1];
          end
          table_keys[slot] = k;
          table_avgs[slot] = a;
          table_count++;
          if (table_count > peak_count) peak_count = table_count;
          queue_result(ST_OK, k, a, 1'b1);
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (table_count == 0) begin
          queue_result(ST_EMPTY, k, '0, 1'b1);
        end else if (slot < 0) begin
          queue_result(ST_NOTFOUND, k, '0, 1'b1);
        end else begin
          a = table_avgs[slot];
          if (op == CMD_REMOVE) begin
            // close the gap
            for (int i = slot; i + 1 < table_count; i++) begin
              table_keys[i] = table_keys[i+1];
              table_avgs[i] = table_avgs[i+1];
            end
            table_count--;
          end
          queue_result(ST_OK, k, a, 1'b1);
        end
      end
      CMD_LIST: begin
        // empty table: one result, key reads as zero
        if (table_count == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < table_count; i++)
            queue_result(ST_OK, table_keys[i], table_avgs[i], i == table_count - 1);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= '0;
    end else if (start && !req_taken) begin
      // request still waiting on busy: hold it
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 3'd1;
    end else if (pending_requests.size() != 0) begin
      nxt         = pending_requests.pop_front();
      start      <= 1'b1;
      cmd        <= nxt.cmd;
      key_in     <= nxt.key;
      average_in <= nxt.avg;
      gap_left   <= nxt.gap;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks strobed results, predicts on every taken request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst) begin
      req_taken   <= 1'b0;
      table_count  = 0;
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: status %0d, key %0d", status, key_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("status", want.status, status);
          check_field("key_out", want.key, key_out);
          check_field("average_out", want.avg, average_out);
          check_field("entry_count", want.count, entry_count);
          check_field("last_result", want.last, last_result);
        end
      end
      // A result never belongs to the request taken on the same edge, so
      // predicting after the check keeps the order right.
      if (start && !busy) apply_table_command(cmd, key_in, average_in);
      req_taken <= start && !busy;
    end
  end

  // Watchdog: no request taken and no result for too long ends the run.
  always @(posedge clk) begin : watchdog
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    logic [CMD_W-1:0] c;

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed: empty table, extreme keys and averages, saturation,
    // duplicate, misses, removal at the ends and in the middle.
    push_request(CMD_LIST,   32'sd0,     14'd0);
    push_request(CMD_SEARCH, 32'sd5,     14'd0);
    push_request(CMD_REMOVE, 32'sd5,     14'h3FFF);
    push_request(CMD_INSERT, 32'sd0,     14'd0);
    push_request(CMD_INSERT, KEY_MAX,    AVG_MAX);
    push_request(CMD_INSERT, KEY_MIN,    14'h3FFF);
    push_request(CMD_INSERT, -32'sd1,    14'd10001);
    push_request(CMD_INSERT, 32'sd0,     14'd1234);
    push_request(CMD_SEARCH, KEY_MIN,    14'd0);
    push_request(CMD_SEARCH, KEY_MAX,    14'd0);
    push_request(CMD_SEARCH, 32'sd12345, 14'd0);
    push_request(CMD_REMOVE, 32'sd12345, 14'd0);
    push_request(CMD_LIST,   KEY_MAX,    14'h3FFF);
    push_request(CMD_REMOVE, 32'sd0,     14'd0);
    push_request(CMD_REMOVE, KEY_MIN,    14'd0);
    push_request(CMD_REMOVE, KEY_MAX,    14'd0);
    push_request(CMD_LIST,   32'sd0,     14'd0);
    push_request(CMD_REMOVE, -32'sd1,    14'd0);
    push_request(CMD_LIST,   KEY_MIN,    14'd0);
    push_request(CMD_INSERT, 32'sd100,   14'h2AAA);
    push_request(CMD_INSERT, 32'sd42,    14'h1555);
    push_request(CMD_SEARCH, 32'sd42,    14'd0);

    // Fill: every pool key in random order takes the table to full, then
    // duplicates and fresh keys hit the full table, then a full-length list.
    shuffle_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      push_request(CMD_INSERT, key_pool[i], draw_avg());
    end
    for (int i = 0; i < 4; i++)
      push_request(CMD_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)], draw_avg());
    push_request(CMD_INSERT, $urandom, draw_avg());
    push_request(CMD_INSERT, $urandom, draw_avg());
    push_request(CMD_LIST, $urandom, draw_avg());

    // Churn: mixed commands around the full mark.
    for (int i = 0; i < 34; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      c = (r < 7) ? CMD_INSERT : (r < 13) ? CMD_REMOVE : (r < 18) ? CMD_SEARCH : CMD_LIST;
      push_request(c, draw_key(), draw_avg());
    end

    // Drain: mostly removes of pool keys, then removes of 100 and 42 and a list of what is left.
    shuffle_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      c = ($urandom_range(0, 9) < 8) ? CMD_REMOVE : CMD_SEARCH;
      push_request(c, key_pool[i], draw_avg());
    end
    push_request(CMD_REMOVE, 32'sd100, draw_avg());
    push_request(CMD_REMOVE, 32'sd42, draw_avg());
    push_request(CMD_LIST, $urandom, draw_avg());

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_requests.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (insert %0d, remove %0d, search %0d, list %0d).",
             cmd_seen[CMD_INSERT] + cmd_seen[CMD_REMOVE] + cmd_seen[CMD_SEARCH] +
             cmd_seen[CMD_LIST], cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE],
             cmd_seen[CMD_SEARCH], cmd_seen[CMD_LIST]);
    $display("Checked %0d results; table peaked at %0d of %0d records.",
             results_checked, peak_count, DEPTH);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
